// ===== sv/qsct_pkg.sv =====
// ----------------------------------------------------------------------------
// qsct_pkg: shared types and constants of the q15 sine/cosine/tangent unit
// quarter-wave sine rom, table geometry, pipeline depths, beat types
// ----------------------------------------------------------------------------
package qsct_pkg;

    // entries per quarter wave, rounded down to a power of two in 16..256
    localparam int TABLE_ENTRIES = 256;

    function automatic int calc_shift();
        int s;
        s = 6;
        while (s < 10 && (16384 >> s) > TABLE_ENTRIES) begin
            s = s + 1;
        end
        return s;
    endfunction

    localparam int TBL_SHIFT = calc_shift();      // fraction bits below the index
    localparam int IDX_W     = 14 - TBL_SHIFT;    // index bits into the quarter wave
    localparam int STRIDE_SH = TBL_SHIFT - 6;     // stride into the 256-entry rom
    localparam int FRAC_W    = TBL_SHIFT;
    localparam int MAG_W     = 15;                // magnitude bits of a q15 value
    localparam int PROD_W    = MAG_W + FRAC_W;
    localparam int Q_W       = 15;                // quotient bits, one per divider cell

    localparam int SINE_LAT  = 4;                 // stages of the sine path
    localparam int LATENCY   = SINE_LAT + 1 + Q_W + 1;

    localparam logic [15:0]        QTR_TURN = 16'd16384;
    localparam logic [MAG_W-1:0]   Q15_ONE  = 15'd32767;
    localparam logic signed [15:0] Q15_MAX  = 16'sd32767;
    localparam logic signed [15:0] Q15_MIN  = -16'sd32768;

    typedef enum logic [1:0] {
        KIND_SIN = 2'd0,
        KIND_COS = 2'd1,
        KIND_TAN = 2'd2
    } t_kind;

    // what rides beside the divider
    typedef struct packed {
        logic               use_q;   // result is the quotient
        logic               neg;     // quotient is negated
        logic signed [15:0] pass;    // result when the quotient is not used
    } t_side;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [Q_W-1:0]   quot;
        t_side            side;
    } t_div_beat;

    // floor(32767 * sin) over a quarter wave, 256 points
    localparam logic [MAG_W-1:0] SIN_ROM [256] = '{
        15'd0, 15'd201, 15'd402, 15'd603, 15'd804, 15'd1005, 15'd1206, 15'd1406,
        15'd1607, 15'd1808, 15'd2009, 15'd2209, 15'd2410, 15'd2610, 15'd2811, 15'd3011,
        15'd3211, 15'd3411, 15'd3611, 15'd3811, 15'd4011, 15'd4210, 15'd4409, 15'd4608,
        15'd4807, 15'd5006, 15'd5205, 15'd5403, 15'd5601, 15'd5799, 15'd5997, 15'd6195,
        15'd6392, 15'd6589, 15'd6786, 15'd6982, 15'd7179, 15'd7375, 15'd7571, 15'd7766,
        15'd7961, 15'd8156, 15'd8351, 15'd8545, 15'd8739, 15'd8932, 15'd9126, 15'd9319,
        15'd9511, 15'd9703, 15'd9895, 15'd10087, 15'd10278, 15'd10469, 15'd10659,
        15'd10849, 15'd11038, 15'd11227, 15'd11416, 15'd11604, 15'd11792, 15'd11980,
        15'd12166, 15'd12353, 15'd12539, 15'd12724, 15'd12909, 15'd13094, 15'd13278,
        15'd13462, 15'd13645, 15'd13827, 15'd14009, 15'd14191, 15'd14372, 15'd14552,
        15'd14732, 15'd14911, 15'd15090, 15'd15268, 15'd15446, 15'd15623, 15'd15799,
        15'd15975, 15'd16150, 15'd16325, 15'd16499, 15'd16672, 15'd16845, 15'd17017,
        15'd17189, 15'd17360, 15'd17530, 15'd17699, 15'd17868, 15'd18036, 15'd18204,
        15'd18371, 15'd18537, 15'd18702, 15'd18867, 15'd19031, 15'd19194, 15'd19357,
        15'd19519, 15'd19680, 15'd19840, 15'd20000, 15'd20159, 15'd20317, 15'd20474,
        15'd20631, 15'd20787, 15'd20942, 15'd21096, 15'd21249, 15'd21402, 15'd21554,
        15'd21705, 15'd21855, 15'd22004, 15'd22153, 15'd22301, 15'd22448, 15'd22594,
        15'd22739, 15'd22883, 15'd23027, 15'd23169, 15'd23311, 15'd23452, 15'd23592,
        15'd23731, 15'd23869, 15'd24006, 15'd24143, 15'd24278, 15'd24413, 15'd24546,
        15'd24679, 15'd24811, 15'd24942, 15'd25072, 15'd25201, 15'd25329, 15'd25456,
        15'd25582, 15'd25707, 15'd25831, 15'd25954, 15'd26077, 15'd26198, 15'd26318,
        15'd26437, 15'd26556, 15'd26673, 15'd26789, 15'd26905, 15'd27019, 15'd27132,
        15'd27244, 15'd27355, 15'd27466, 15'd27575, 15'd27683, 15'd27790, 15'd27896,
        15'd28001, 15'd28105, 15'd28208, 15'd28309, 15'd28410, 15'd28510, 15'd28608,
        15'd28706, 15'd28802, 15'd28897, 15'd28992, 15'd29085, 15'd29177, 15'd29268,
        15'd29358, 15'd29446, 15'd29534, 15'd29621, 15'd29706, 15'd29790, 15'd29873,
        15'd29955, 15'd30036, 15'd30116, 15'd30195, 15'd30272, 15'd30349, 15'd30424,
        15'd30498, 15'd30571, 15'd30643, 15'd30713, 15'd30783, 15'd30851, 15'd30918,
        15'd30984, 15'd31049, 15'd31113, 15'd31175, 15'd31236, 15'd31297, 15'd31356,
        15'd31413, 15'd31470, 15'd31525, 15'd31580, 15'd31633, 15'd31684, 15'd31735,
        15'd31785, 15'd31833, 15'd31880, 15'd31926, 15'd31970, 15'd32014, 15'd32056,
        15'd32097, 15'd32137, 15'd32176, 15'd32213, 15'd32249, 15'd32284, 15'd32318,
        15'd32350, 15'd32382, 15'd32412, 15'd32441, 15'd32468, 15'd32495, 15'd32520,
        15'd32544, 15'd32567, 15'd32588, 15'd32609, 15'd32628, 15'd32646, 15'd32662,
        15'd32678, 15'd32692, 15'd32705, 15'd32717, 15'd32727, 15'd32736, 15'd32744,
        15'd32751, 15'd32757, 15'd32761, 15'd32764, 15'd32766
    };

endpackage

// ===== sv/qsct_sine_path.sv =====
// ----------------------------------------------------------------------------
// qsct_sine_path: four-stage full-wave q15 sine
// quadrant fold, rom lookup, interpolation multiply, add and sign
// ----------------------------------------------------------------------------
module qsct_sine_path (
    input  logic               i_clk,
    input  logic               i_interp,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_value
);
    import qsct_pkg::*;

    logic [13:0]        fold;
    logic               r1_neg;
    logic [IDX_W-1:0]   r1_idx;
    logic [FRAC_W-1:0]  r1_frac;
    logic               r1_interp;

    logic [7:0]         addr_here;
    logic [7:0]         addr_next;
    logic [IDX_W-1:0]   idx_inc;
    logic [MAG_W-1:0]   here;
    logic [MAG_W-1:0]   next_val;
    logic [MAG_W-1:0]   n_diff;
    logic               r2_neg;
    logic [MAG_W-1:0]   r2_here;
    logic [MAG_W-1:0]   r2_diff;
    logic [FRAC_W-1:0]  r2_frac;

    logic [PROD_W-1:0]  n_prod;
    logic               r3_neg;
    logic [MAG_W-1:0]   r3_here;
    logic [PROD_W-1:0]  r3_prod;

    logic [MAG_W-1:0]   sum;
    logic signed [15:0] n_value;

    // mirror in the second and fourth quadrants, negate in the lower half
    assign fold = i_angle[14] ? ~i_angle[13:0] : i_angle[13:0];

    assign idx_inc   = r1_idx + 1'b1;
    assign addr_here = 8'(r1_idx) << STRIDE_SH;
    assign addr_next = 8'(idx_inc) << STRIDE_SH;
    assign here      = SIN_ROM[addr_here];
    assign next_val  = (&r1_idx) ? Q15_ONE : SIN_ROM[addr_next];
    assign n_diff    = r1_interp ? MAG_W'(next_val - here) : '0;

    assign n_prod = PROD_W'(r2_frac) * PROD_W'(r2_diff);

    assign sum     = r3_here + MAG_W'(r3_prod >> FRAC_W);
    assign n_value = r3_neg ? -signed'({1'b0, sum}) : signed'({1'b0, sum});

    always_ff @(posedge i_clk) begin
        r1_neg    <= i_angle[15];
        r1_idx    <= fold[13:TBL_SHIFT];
        r1_frac   <= fold[TBL_SHIFT-1:0];
        r1_interp <= i_interp;

        r2_neg    <= r1_neg;
        r2_here   <= here;
        r2_diff   <= n_diff;
        r2_frac   <= r1_frac;

        r3_neg    <= r2_neg;
        r3_here   <= r2_here;
        r3_prod   <= n_prod;

        o_value   <= n_value;
    end

endmodule

// ===== sv/qsct_div_cell.sv =====
// ----------------------------------------------------------------------------
// qsct_div_cell: one restoring division step
// shifts the remainder, subtracts the divisor when it fits, adds one quotient bit
// ----------------------------------------------------------------------------
module qsct_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  qsct_pkg::t_div_beat i_beat,
    output logic                o_valid,
    output qsct_pkg::t_div_beat o_beat
);
    import qsct_pkg::*;

    logic [MAG_W:0]  rem2;
    logic            fits;
    t_div_beat       n_beat;

    assign rem2 = {i_beat.rem, 1'b0};
    assign fits = rem2 >= {1'b0, i_beat.den};

    always_comb begin
        n_beat      = i_beat;
        n_beat.rem  = fits ? MAG_W'(rem2 - {1'b0, i_beat.den}) : rem2[MAG_W-1:0];
        n_beat.quot = {i_beat.quot[Q_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_beat <= n_beat;
    end

endmodule

// ===== sv/q15_sine_cosine_tangent_unit.sv =====
// ----------------------------------------------------------------------------
// q15_sine_cosine_tangent_unit: q15 sine, cosine and tangent of a 16-bit angle
// quarter-wave rom with linear interpolation, tangent by a chain of divider cells
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ---------------------------
//  command   in         start high, busy low    i_kind, i_angle
//  result    out        o_strobe, one cycle     o_value
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (interpolate)
//
//  one command beat per clock, no gaps needed; busy never rises
//  a result strobes once its command beat has passed through the four sine-path stages,
//  one prep stage, 15 divider cells and the output register
//  sine and cosine run through the divider chain too so every kind has the same latency
//  the receiver cannot stall; results leave from the output register unconditionally
//  synchronous active-low reset clears valid bits and sets interpolate to 1
//
module q15_sine_cosine_tangent_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_angle,
    output logic               o_strobe,
    output logic signed [15:0] o_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import qsct_pkg::*;

    // configuration
    logic                r_interp;

    // command accept and the valid/kind line beside the sine paths
    logic                accept;
    logic [SINE_LAT-1:0] r_vld_pipe;
    logic [1:0]          r_kind_pipe [SINE_LAT];

    // the two sine paths
    logic [15:0]         cos_angle;
    logic signed [15:0]  sin_v;
    logic signed [15:0]  cos_v;

    // prep stage: magnitudes, saturation, selection among sine, cosine and tangent
    logic [MAG_W-1:0]    abs_s;
    logic [MAG_W-1:0]    abs_c;
    logic                sat;
    logic                q_neg;
    t_div_beat           n_prep;
    logic                r_prep_vld;
    t_div_beat           r_prep;

    // divider chain
    logic [Q_W:0]        chain_vld;
    t_div_beat           chain_beat [Q_W+1];

    // output stage
    t_div_beat           last_beat;
    logic [Q_W-1:0]      quot;
    logic signed [15:0]  n_value;
    logic                r_strobe;
    logic signed [15:0]  r_value;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_interp <= i_cfg_data;
        end
    end

    // valid bits follow the command through the sine paths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[SINE_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind_pipe[0] <= i_kind;
        for (int k = 1; k < SINE_LAT; k++) begin
            r_kind_pipe[k] <= r_kind_pipe[k-1];
        end
    end

    // cosine is the sine a quarter turn ahead; wraps mod 65536
    assign cos_angle = i_angle + QTR_TURN;

    qsct_sine_path u_sin (
        .i_clk    (i_clk),
        .i_interp (r_interp),
        .i_angle  (i_angle),
        .o_value  (sin_v)
    );

    qsct_sine_path u_cos (
        .i_clk    (i_clk),
        .i_interp (r_interp),
        .i_angle  (cos_angle),
        .o_value  (cos_v)
    );

    // tangent saturates when |sin| >= |cos|; otherwise |sin|/|cos| goes to the divider
    assign abs_s = sin_v[15] ? MAG_W'(-sin_v) : sin_v[MAG_W-1:0];
    assign abs_c = cos_v[15] ? MAG_W'(-cos_v) : cos_v[MAG_W-1:0];
    assign sat   = abs_s >= abs_c;
    assign q_neg = sin_v[15] ^ cos_v[15];

    always_comb begin
        n_prep            = '0;
        n_prep.rem        = abs_s;
        n_prep.den        = abs_c;
        n_prep.side.neg   = q_neg;
        unique case (r_kind_pipe[SINE_LAT-1])
            KIND_SIN: begin
                n_prep.side.pass = sin_v;
            end
            KIND_COS: begin
                n_prep.side.pass = cos_v;
            end
            KIND_TAN: begin
                n_prep.side.use_q = !sat;
                n_prep.side.pass  = q_neg ? Q15_MIN : Q15_MAX;
            end
            default: begin
                n_prep.side.pass = '0;   // unused kind answers zero
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else begin
            r_prep_vld <= r_vld_pipe[SINE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    // one quotient bit per cell, msb first
    assign chain_vld[0]  = r_prep_vld;
    assign chain_beat[0] = r_prep;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        qsct_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_vld[g]),
            .i_beat  (chain_beat[g]),
            .o_valid (chain_vld[g+1]),
            .o_beat  (chain_beat[g+1])
        );
    end

    // quotient is below 32768 since |sin| < |cos|; sign applied last (truncation toward zero)
    assign last_beat = chain_beat[Q_W];
    assign quot      = last_beat.quot;

    always_comb begin
        if (last_beat.side.use_q) begin
            n_value = last_beat.side.neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
        end else begin
            n_value = last_beat.side.pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= chain_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_strobe = r_strobe;
    assign o_value  = r_value;

endmodule

// ===== sv/qsct_checker.sv =====
// ----------------------------------------------------------------------------
// qsct_checker: port-level checks of the sine/cosine/tangent unit
// fixed latency in both directions, range of sine and cosine, unused kind
// ----------------------------------------------------------------------------
module qsct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_kind,
    input logic               o_strobe,
    input logic signed [15:0] o_value
);
    import qsct_pkg::*;

    // every command beat yields a result after the fixed latency
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("command beat without result");

    // no result without a command beat the fixed latency earlier
    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without command beat");

    // sine and cosine stay within -32767..32767
    a_sincos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_kind, LATENCY) == KIND_SIN
                      || $past(i_kind, LATENCY) == KIND_COS))
        |-> (o_value != Q15_MIN))
        else $error("sine or cosine out of range");

    // the unused kind answers zero
    a_unused_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_kind, LATENCY) != KIND_SIN
                  && $past(i_kind, LATENCY) != KIND_COS
                  && $past(i_kind, LATENCY) != KIND_TAN)
        |-> (o_value == '0))
        else $error("unused kind gave nonzero value");

endmodule

bind q15_sine_cosine_tangent_unit qsct_checker u_qsct_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_kind   (i_kind),
    .o_strobe (o_strobe),
    .o_value  (o_value)
);
